// ===== rtl/cau_pkg.sv =====
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int RATIO_BITS = 30;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_MAG  = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;

  typedef struct packed {
    logic [2:0]                   op;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } cau_cmd_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         overflow;
    logic                         div_zero;
  } cau_res_t;

endpackage

// ===== rtl/cau_div.sv =====
module cau_div
  import cau_pkg::*;
#(
  parameter int DW = DATA_WIDTH,
  parameter int QW = DATA_WIDTH
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] bits_in,
  input  logic [DW-1:0] div_in,
  output logic [QW-1:0] quo
);

  // one quotient bit per stage, restoring
  logic [DW-1:0] rem_r  [QW];
  logic [DW-1:0] dv_r   [QW];
  logic [QW-1:0] bits_r [QW];
  logic [QW-1:0] q_r    [QW];
  logic [DW-1:0] rem_next  [QW];
  logic [DW-1:0] dv_next   [QW];
  logic [QW-1:0] bits_next [QW];
  logic [QW-1:0] q_next    [QW];

  always_comb begin
    logic [DW-1:0] rem_src;
    logic [DW-1:0] dv_src;
    logic [QW-1:0] bits_src;
    logic [QW-1:0] q_src;
    logic [DW:0]   sh;
    logic [DW:0]   diff;
    logic          ge;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        rem_src  = rem_in;
        dv_src   = div_in;
        bits_src = bits_in;
        q_src    = '0;
      end else begin
        rem_src  = rem_r[i-1];
        dv_src   = dv_r[i-1];
        bits_src = bits_r[i-1];
        q_src    = q_r[i-1];
      end
      sh   = {rem_src, bits_src[QW-1]};
      diff = sh - {1'b0, dv_src};
      ge   = (sh >= {1'b0, dv_src});
      rem_next[i]  = ge ? diff[DW-1:0] : sh[DW-1:0];
      dv_next[i]   = dv_src;
      bits_next[i] = bits_src << 1;
      q_next[i]    = {q_src[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QW; i++) begin
      rem_r[i]  <= rem_next[i];
      dv_r[i]   <= dv_next[i];
      bits_r[i] <= bits_next[i];
      q_r[i]    <= q_next[i];
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ===== rtl/cau_sqrt.sv =====
module cau_sqrt
  import cau_pkg::*;
#(
  parameter int RW = DATA_WIDTH
) (
  input  logic            clk,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  // one root bit per stage, floor result
  logic [RW:0]     rem_r  [RW];
  logic [2*RW-1:0] x_r    [RW];
  logic [RW-1:0]   root_r [RW];
  logic [RW:0]     rem_next  [RW];
  logic [2*RW-1:0] x_next    [RW];
  logic [RW-1:0]   root_next [RW];

  always_comb begin
    logic [RW:0]     rem_src;
    logic [2*RW-1:0] x_src;
    logic [RW-1:0]   root_src;
    logic [RW+2:0]   sh;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;
    for (int i = 0; i < RW; i++) begin
      if (i == 0) begin
        rem_src  = '0;
        x_src    = rad;
        root_src = '0;
      end else begin
        rem_src  = rem_r[i-1];
        x_src    = x_r[i-1];
        root_src = root_r[i-1];
      end
      sh    = {rem_src, x_src[2*RW-1 -: 2]};
      trial = {1'b0, root_src, 2'b01};
      diff  = sh - trial;
      ge    = (sh >= trial);
      rem_next[i]  = ge ? diff[RW:0] : sh[RW:0];
      x_next[i]    = x_src << 2;
      root_next[i] = {root_src[RW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RW; i++) begin
      rem_r[i]  <= rem_next[i];
      x_r[i]    <= x_next[i];
      root_r[i] <= root_next[i];
    end
  end

  assign root = root_r[RW-1];

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// channel   | ports                 | transfer
// ----------+-----------------------+------------------------------------
// command   | start, busy, cmd      | edge with start high and busy low
// result    | done, res             | one cycle with done high, no hold-off
//
// fully pipelined: one command per clock, busy is never raised
// every operation has the same latency from command to result,
// set by the ratio divider (31 stages), the scale root (31), the half-angle
// root (24) and the quotient dividers (32), one bit per stage
// rst (synchronous) clears the valid bits only; results come in command order
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cau_cmd_t cmd,
  output logic     done,
  output cau_res_t res
);

  localparam int RQ  = RATIO_BITS + 1;
  localparam int SR1 = RATIO_BITS + 1;
  localparam int SR2 = 24;
  localparam int QQ  = DATA_WIDTH;
  localparam int QD  = DATA_WIDTH + 1;

  localparam logic signed [31:0] MAXV   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV   = 32'sh8000_0000;
  localparam logic signed [48:0] SMAX49 = 49'sh7FFF_FFFF;
  localparam logic signed [48:0] SMIN49 = -49'sh8000_0000;

  typedef struct packed {
    logic              valid;
    logic [2:0]        op;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
    logic              swap;
    logic              rneg;
    logic              dz;
    logic [31:0]       hi;
    logic signed [31:0] e_re;
    logic signed [31:0] e_im;
    logic              e_ovf;
    logic signed [33:0] den;
    logic signed [33:0] nre;
    logic signed [33:0] nim;
    logic [31:0]       m;
    logic [23:0]       root;
    logic [32:0]       ua;
    logic [32:0]       ub;
    logic [32:0]       ud;
    logic              nega;
    logic              negb;
    logic              biga;
    logic              bigb;
  } ctx_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               o;
  } sat_t;

  function automatic sat_t sat49(input logic signed [48:0] x);
    sat_t r;
    r.v = x[31:0];
    r.o = 1'b0;
    if (x > SMAX49) begin
      r.v = MAXV;
      r.o = 1'b1;
    end else if (x < SMIN49) begin
      r.v = MINV;
      r.o = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [32:0] mag34(input logic signed [33:0] x);
    logic [33:0] t;
    t = x[33] ? (~x + 34'd1) : x;
    return t[32:0];
  endfunction

  // quotient to signed result, clipped
  function automatic sat_t qfin(input logic [31:0] q, input logic neg, input logic big);
    sat_t r;
    r.o = 1'b0;
    if (!neg) begin
      r.v = q;
      if (big || q[31]) begin
        r.v = MAXV;
        r.o = 1'b1;
      end
    end else begin
      r.v = -q;
      if (big || (q[31] && (|q[30:0]))) begin
        r.v = MINV;
        r.o = 1'b1;
      end
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // input register
  logic     v0;
  cau_cmd_t c0;

  always_ff @(posedge clk) begin
    v0 <= start & ~busy & ~rst;
    c0 <= cmd;
  end

  // operand magnitudes, ordering and the four complex products
  ctx_t               c1, c1_next;
  logic [31:0]        lo1, lo1_next;
  logic signed [63:0] prr, pii, pri, pir;

  always_comb begin
    logic [31:0] u1;
    logic [31:0] u2;
    logic        gt;
    if (c0.op == OP_DIV) begin
      u1 = mag32(c0.b_re);
      u2 = mag32(c0.b_im);
    end else begin
      u1 = mag32(c0.a_re);
      u2 = mag32(c0.a_im);
    end
    gt = (u1 > u2);
    c1_next       = '0;
    c1_next.valid = v0;
    c1_next.op    = c0.op;
    c1_next.ar    = c0.a_re;
    c1_next.ai    = c0.a_im;
    c1_next.br    = c0.b_re;
    c1_next.bi    = c0.b_im;
    c1_next.swap  = ~gt;
    c1_next.rneg  = c0.b_re[31] ^ c0.b_im[31];
    c1_next.dz    = ~gt & (c0.b_im == '0);
    c1_next.hi    = gt ? u1 : u2;
    lo1_next      = gt ? u2 : u1;
  end

  always_ff @(posedge clk) begin
    lo1 <= lo1_next;
    prr <= c0.a_re * c0.b_re;
    pii <= c0.a_im * c0.b_im;
    pri <= c0.a_re * c0.b_im;
    pir <= c0.a_im * c0.b_re;
    if (rst) begin
      c1.valid <= 1'b0;
    end else begin
      c1 <= c1_next;
    end
  end

  // add, subtract and multiply finish here
  ctx_t c1e;

  always_comb begin
    logic signed [32:0] sre;
    logic signed [32:0] sim;
    logic signed [64:0] mre;
    logic signed [64:0] mim;
    sat_t               r_re;
    sat_t               r_im;
    c1e = c1;
    sre = '0;
    sim = '0;
    mre = 65'(prr) - 65'(pii);
    mim = 65'(pri) + 65'(pir);
    case (c1.op)
      OP_ADD: begin
        sre = 33'(c1.ar) + 33'(c1.br);
        sim = 33'(c1.ai) + 33'(c1.bi);
      end
      OP_SUB: begin
        sre = 33'(c1.ar) - 33'(c1.br);
        sim = 33'(c1.ai) - 33'(c1.bi);
      end
      default: begin
      end
    endcase
    if (c1.op == OP_MUL) begin
      r_re = sat49($signed(mre[64:16]));
      r_im = sat49($signed(mim[64:16]));
    end else begin
      r_re = sat49(49'(sre));
      r_im = sat49(49'(sim));
    end
    c1e.e_re  = r_re.v;
    c1e.e_im  = r_im.v;
    c1e.e_ovf = r_re.o | r_im.o;
  end

  // ratio of smaller to larger magnitude, Q.30
  logic [RQ-1:0] rq;

  cau_div #(
    .DW(DATA_WIDTH),
    .QW(RQ)
  ) u_ratio (
    .clk    (clk),
    .rem_in ({1'b0, lo1[31:1]}),
    .bits_in({lo1[0], {RATIO_BITS{1'b0}}}),
    .div_in (c1.hi),
    .quo    (rq)
  );

  ctx_t line1 [RQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RQ; k++) begin
        line1[k].valid <= 1'b0;
      end
    end else begin
      line1[0] <= c1e;
      for (int k = 1; k < RQ; k++) begin
        line1[k] <= line1[k-1];
      end
    end
  end

  // products with the signed ratio and its square
  ctx_t               cp;
  logic signed [63:0] mq, mx, my;
  logic [61:0]        sq;
  logic signed [63:0] mq_next, mx_next, my_next;

  always_comb begin
    logic signed [31:0] ratio;
    logic signed [31:0] pq;
    logic signed [31:0] px;
    logic signed [31:0] py;
    ratio = line1[RQ-1].rneg ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
    pq = line1[RQ-1].swap ? line1[RQ-1].br : line1[RQ-1].bi;
    px = line1[RQ-1].swap ? line1[RQ-1].ai : line1[RQ-1].ar;
    py = line1[RQ-1].swap ? line1[RQ-1].ar : line1[RQ-1].ai;
    mq_next = pq * ratio;
    mx_next = px * ratio;
    my_next = py * ratio;
  end

  always_ff @(posedge clk) begin
    mq <= mq_next;
    mx <= mx_next;
    my <= my_next;
    sq <= rq * rq;
    if (rst) begin
      cp.valid <= 1'b0;
    end else begin
      cp <= line1[RQ-1];
    end
  end

  // scaled numerators and denominator of the divide
  ctx_t        cq, cq_next;
  logic [61:0] sqin1;

  always_comb begin
    logic signed [31:0] pp;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [33:0] nim0;
    pp = cp.swap ? cp.bi : cp.br;
    px = cp.swap ? cp.ai : cp.ar;
    py = cp.swap ? cp.ar : cp.ai;
    nim0 = 34'(py) - $signed(mx[63:30]);
    cq_next     = cp;
    cq_next.den = 34'(pp) + $signed(mq[63:30]);
    cq_next.nre = 34'(px) + $signed(my[63:30]);
    cq_next.nim = cp.swap ? -nim0 : nim0;
    cq_next.dz  = cp.dz | (cq_next.den == '0);
  end

  always_ff @(posedge clk) begin
    sqin1 <= (62'd1 << (2 * RATIO_BITS)) + sq;
    if (rst) begin
      cq.valid <= 1'b0;
    end else begin
      cq <= cq_next;
    end
  end

  // sqrt(1 + ratio^2) in Q.30
  logic [SR1-1:0] s1r;

  cau_sqrt #(
    .RW(SR1)
  ) u_scale_root (
    .clk (clk),
    .rad (sqin1),
    .root(s1r)
  );

  ctx_t line2 [SR1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SR1; k++) begin
        line2[k].valid <= 1'b0;
      end
    end else begin
      line2[0] <= cq;
      for (int k = 1; k < SR1; k++) begin
        line2[k] <= line2[k-1];
      end
    end
  end

  ctx_t        cm;
  logic [62:0] mprod;

  always_ff @(posedge clk) begin
    mprod <= line2[SR1-1].hi * s1r;
    if (rst) begin
      cm.valid <= 1'b0;
    end else begin
      cm <= line2[SR1-1];
    end
  end

  // magnitude, and the half sum for the root
  ctx_t        cn, cn_next;
  logic [47:0] sqin2, sqin2_next;

  always_comb begin
    logic [32:0] msum;
    cn_next   = cm;
    cn_next.m = mprod[61:30];
    msum = {1'b0, mprod[61:30]} + {1'b0, mag32(cm.ar)};
    sqin2_next = {msum[32:1], {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    sqin2 <= sqin2_next;
    if (rst) begin
      cn.valid <= 1'b0;
    end else begin
      cn <= cn_next;
    end
  end

  logic [SR2-1:0] r2;

  cau_sqrt #(
    .RW(SR2)
  ) u_half_root (
    .clk (clk),
    .rad (sqin2),
    .root(r2)
  );

  ctx_t line3 [SR2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SR2; k++) begin
        line3[k].valid <= 1'b0;
      end
    end else begin
      line3[0] <= cn;
      for (int k = 1; k < SR2; k++) begin
        line3[k] <= line3[k-1];
      end
    end
  end

  // quotient operands: divide uses both lanes, root uses lane a
  ctx_t cr, cr_next;

  always_comb begin
    logic signed [33:0] na;
    logic signed [33:0] da;
    logic signed [33:0] nb;
    na = (line3[SR2-1].op == OP_SQRT) ? 34'(line3[SR2-1].ai) : line3[SR2-1].nre;
    da = (line3[SR2-1].op == OP_SQRT) ? $signed({9'b0, r2, 1'b0}) : line3[SR2-1].den;
    nb = line3[SR2-1].nim;
    cr_next      = line3[SR2-1];
    cr_next.root = r2;
    cr_next.ua   = mag34(na);
    cr_next.ub   = mag34(nb);
    cr_next.ud   = mag34(da);
    cr_next.nega = na[33] ^ da[33];
    cr_next.negb = nb[33] ^ da[33];
    cr_next.biga = ({16'b0, cr_next.ua} >= {cr_next.ud, 16'b0});
    cr_next.bigb = ({16'b0, cr_next.ub} >= {cr_next.ud, 16'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr.valid <= 1'b0;
    end else begin
      cr <= cr_next;
    end
  end

  logic [QQ-1:0] qa, qb;

  cau_div #(
    .DW(QD),
    .QW(QQ)
  ) u_quo_a (
    .clk    (clk),
    .rem_in ({16'b0, cr.ua[32:16]}),
    .bits_in({cr.ua[15:0], 16'b0}),
    .div_in (cr.ud),
    .quo    (qa)
  );

  cau_div #(
    .DW(QD),
    .QW(QQ)
  ) u_quo_b (
    .clk    (clk),
    .rem_in ({16'b0, cr.ub[32:16]}),
    .bits_in({cr.ub[15:0], 16'b0}),
    .div_in (cr.ud),
    .quo    (qb)
  );

  ctx_t line4 [QQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QQ; k++) begin
        line4[k].valid <= 1'b0;
      end
    end else begin
      line4[0] <= cr;
      for (int k = 1; k < QQ; k++) begin
        line4[k] <= line4[k-1];
      end
    end
  end

  // result selection
  cau_res_t res_next;

  always_comb begin
    sat_t        fa;
    sat_t        fb;
    logic [31:0] rt;
    fa = qfin(qa, line4[QQ-1].nega, line4[QQ-1].biga);
    fb = qfin(qb, line4[QQ-1].negb, line4[QQ-1].bigb);
    rt = {8'b0, line4[QQ-1].root};
    res_next = '0;
    case (line4[QQ-1].op)
      OP_ADD, OP_SUB, OP_MUL: begin
        res_next.res_re   = line4[QQ-1].e_re;
        res_next.res_im   = line4[QQ-1].e_im;
        res_next.overflow = line4[QQ-1].e_ovf;
      end
      OP_DIV: begin
        if (line4[QQ-1].dz) begin
          res_next.div_zero = 1'b1;
        end else begin
          res_next.res_re   = fa.v;
          res_next.res_im   = fb.v;
          res_next.overflow = fa.o | fb.o;
        end
      end
      OP_MAG: begin
        if (line4[QQ-1].m[31]) begin
          res_next.res_re   = MAXV;
          res_next.overflow = 1'b1;
        end else begin
          res_next.res_re = line4[QQ-1].m;
        end
      end
      OP_SQRT: begin
        if (line4[QQ-1].m == '0) begin
          res_next = '0;
        end else if (!line4[QQ-1].ar[31]) begin
          res_next.res_re = rt;
          if (rt != '0) begin
            res_next.res_im   = fa.v;
            res_next.overflow = fa.o;
          end
        end else if (fa.v[31]) begin
          // flip to the right half plane; the most negative quotient clips
          res_next.res_re   = (fa.v == MINV) ? MAXV : -fa.v;
          res_next.res_im   = -rt;
          res_next.overflow = fa.o | (fa.v == MINV);
        end else begin
          res_next.res_re   = fa.v;
          res_next.res_im   = rt;
          res_next.overflow = fa.o;
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= line4[QQ-1].valid;
    end
  end

endmodule
